// ===== design/lzfbd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LZSS flag-byte decompressor package
// Shared widths, codes and the command and result item types.
// ----------------------------------------------------------------------------
package lzfbd_pkg;

    localparam int WIN_AW   = 12;
    localparam int CNT_W    = 20;
    localparam int RUN_W    = 5;
    localparam int LEN_BIAS = 3;
    localparam int Q_DEPTH  = 4;
    localparam int Q_AW     = 2;

    localparam logic [CNT_W-1:0] COUNT_MAX   = 20'hFFFFF;
    localparam logic [CNT_W-1:0] LIMIT_RESET = 20'd147456;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_TRUNC_LIT = 3'd1;
    localparam logic [2:0] ST_TRUNC_REF = 3'd2;
    localparam logic [2:0] ST_ZERO_DIST = 3'd3;
    localparam logic [2:0] ST_OVERFLOW  = 3'd4;

    localparam logic [1:0] OP_NONE = 2'd0;
    localparam logic [1:0] OP_LIT  = 2'd1;
    localparam logic [1:0] OP_REF  = 2'd2;

    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_STAT = 1'b1;

    typedef struct packed {
        logic [1:0]        op;
        logic [7:0]        data;
        logic [WIN_AW-1:0] ref_dist;
        logic [RUN_W-1:0]  len;
        logic [2:0]        code;
        logic              eos;
    } cmd_t;

    typedef struct packed {
        logic             kind;
        logic [7:0]       data;
        logic [2:0]       status;
        logic [CNT_W-1:0] count;
        logic             run_end;
    } res_t;

endpackage

// ===== design/lzfbd_cq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LZSS command queue
// Short queue of decoded commands between the parser and the copy engine.
// ----------------------------------------------------------------------------
module lzfbd_cq
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr,
    input  lzfbd_pkg::cmd_t  wdata,
    output logic             full,
    input  logic             rd,
    output lzfbd_pkg::cmd_t  rdata,
    output logic             empty
);

    lzfbd_pkg::cmd_t                 mem_reg [lzfbd_pkg::Q_DEPTH];
    logic [lzfbd_pkg::Q_AW-1:0]      wptr_reg;
    logic [lzfbd_pkg::Q_AW-1:0]      rptr_reg;
    logic [lzfbd_pkg::Q_AW:0]        count_reg;
    logic [lzfbd_pkg::Q_AW:0]        count_next;
    logic                            do_wr;
    logic                            do_rd;

    assign full  = (count_reg == (lzfbd_pkg::Q_AW+1)'(lzfbd_pkg::Q_DEPTH));
    assign empty = (count_reg == '0);
    assign do_wr = wr && !full;
    assign do_rd = rd && !empty;
    assign rdata = mem_reg[rptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wptr_reg <= wptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rptr_reg <= rptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wptr_reg] <= wdata;
        end
    end

endmodule

// ===== design/lzfbd_oq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LZSS result queue
// Output queue of data and status items toward the consumer.
// ----------------------------------------------------------------------------
module lzfbd_oq
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr,
    input  lzfbd_pkg::res_t  wdata,
    output logic             full,
    input  logic             rd,
    output lzfbd_pkg::res_t  rdata,
    output logic             empty
);

    lzfbd_pkg::res_t                 mem_reg [lzfbd_pkg::Q_DEPTH];
    logic [lzfbd_pkg::Q_AW-1:0]      wptr_reg;
    logic [lzfbd_pkg::Q_AW-1:0]      rptr_reg;
    logic [lzfbd_pkg::Q_AW:0]        count_reg;
    logic [lzfbd_pkg::Q_AW:0]        count_next;
    logic                            do_wr;
    logic                            do_rd;

    assign full  = (count_reg == (lzfbd_pkg::Q_AW+1)'(lzfbd_pkg::Q_DEPTH));
    assign empty = (count_reg == '0);
    assign do_wr = wr && !full;
    assign do_rd = rd && !empty;
    assign rdata = mem_reg[rptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wptr_reg <= wptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rptr_reg <= rptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wptr_reg] <= wdata;
        end
    end

endmodule

// ===== design/lzfbd_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LZSS token parser
// Accepts compressed bytes, tracks flag bits and emits copy-engine commands.
// ----------------------------------------------------------------------------
module lzfbd_front
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [7:0]       in_byte,
    input  logic             in_last,
    input  logic             cq_full,
    output logic             cmd_push,
    output lzfbd_pkg::cmd_t  cmd
);

    localparam logic [1:0] PH_FLAG = 2'd0;
    localparam logic [1:0] PH_LIT  = 2'd1;
    localparam logic [1:0] PH_REF1 = 2'd2;
    localparam logic [1:0] PH_REF2 = 2'd3;

    logic [1:0]                   phase_reg;
    logic [1:0]                   phase_next;
    logic [7:0]                   flags_reg;
    logic [7:0]                   flags_next;
    logic [2:0]                   left_reg;
    logic [2:0]                   left_next;
    logic [7:0]                   first_reg;
    logic [7:0]                   first_next;
    logic                         drop_reg;
    logic                         drop_next;
    logic                         accept;
    logic                         advance;
    logic [lzfbd_pkg::WIN_AW-1:0] ref_dist;

    assign accept   = push && !cq_full;
    assign ref_dist = {first_reg[7:4], in_byte};

    always_comb
    begin
        phase_next = phase_reg;
        flags_next = flags_reg;
        left_next  = left_reg;
        first_next = first_reg;
        drop_next  = drop_reg;
        advance    = 1'b0;
        cmd_push   = 1'b0;
        cmd        = '0;
        cmd.op     = lzfbd_pkg::OP_NONE;
        cmd.code   = lzfbd_pkg::ST_OK;
        cmd.eos    = in_last;
        if (accept)
        begin
            if (drop_reg)
            begin
                if (in_last)
                begin
                    drop_next  = 1'b0;
                    phase_next = PH_FLAG;
                    flags_next = '0;
                    left_next  = '0;
                    first_next = '0;
                end
            end
            else
            begin
                case (phase_reg)
                    PH_FLAG:
                    begin
                        flags_next = in_byte;
                        left_next  = 3'd7;
                        phase_next = in_byte[7] ? PH_LIT : PH_REF1;
                        if (in_last)
                        begin
                            cmd_push = 1'b1;
                            cmd.code = in_byte[7] ? lzfbd_pkg::ST_TRUNC_LIT
                                                  : lzfbd_pkg::ST_TRUNC_REF;
                        end
                    end
                    PH_LIT:
                    begin
                        cmd_push = 1'b1;
                        cmd.op   = lzfbd_pkg::OP_LIT;
                        cmd.data = in_byte;
                        advance  = 1'b1;
                    end
                    PH_REF1:
                    begin
                        first_next = in_byte;
                        phase_next = PH_REF2;
                        if (in_last)
                        begin
                            cmd_push = 1'b1;
                            cmd.code = lzfbd_pkg::ST_TRUNC_REF;
                        end
                    end
                    PH_REF2:
                    begin
                        cmd_push = 1'b1;
                        if (ref_dist == '0)
                        begin
                            cmd.code = lzfbd_pkg::ST_ZERO_DIST;
                            cmd.eos  = 1'b1;
                            drop_next = !in_last;
                        end
                        else
                        begin
                            cmd.op       = lzfbd_pkg::OP_REF;
                            cmd.ref_dist = ref_dist;
                            cmd.len      = lzfbd_pkg::RUN_W'(first_reg[3:0])
                                         + lzfbd_pkg::RUN_W'(lzfbd_pkg::LEN_BIAS);
                            advance      = 1'b1;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_FLAG;
                    end
                endcase
                if (advance)
                begin
                    if (left_reg == '0)
                    begin
                        phase_next = PH_FLAG;
                    end
                    else
                    begin
                        left_next  = left_reg - 1'b1;
                        phase_next = flags_reg[left_reg - 1'b1] ? PH_LIT : PH_REF1;
                    end
                end
                if (in_last)
                begin
                    phase_next = PH_FLAG;
                    flags_next = '0;
                    left_next  = '0;
                    first_next = '0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_FLAG;
            flags_reg <= '0;
            left_reg  <= '0;
            first_reg <= '0;
            drop_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            flags_reg <= flags_next;
            left_reg  <= left_next;
            first_reg <= first_next;
            drop_reg  <= drop_next;
        end
    end

endmodule

// ===== design/lzfbd_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LZSS copy engine
// Executes commands against the 4 KiB history and produces result items.
// ----------------------------------------------------------------------------
module lzfbd_back
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  lzfbd_pkg::cmd_t               cmd,
    input  logic                          cq_empty,
    output logic                          cq_pop,
    input  logic [lzfbd_pkg::CNT_W-1:0]   limit,
    input  logic                          oq_full,
    output logic                          res_push,
    output lzfbd_pkg::res_t               res
);

    localparam logic [1:0] BS_IDLE = 2'd0;
    localparam logic [1:0] BS_COPY = 2'd1;
    localparam logic [1:0] BS_STAT = 2'd2;

    localparam int AW = lzfbd_pkg::WIN_AW;
    localparam int CW = lzfbd_pkg::CNT_W;
    localparam int RW = lzfbd_pkg::RUN_W;

    logic [7:0]    hist_mem [1 << AW];

    logic [1:0]    state_reg;
    logic [1:0]    state_next;
    logic [AW-1:0] ptr_reg;
    logic [AW-1:0] ptr_next;
    logic [CW-1:0] produced_reg;
    logic [CW-1:0] produced_next;
    logic          drop_reg;
    logic          drop_next;
    logic [AW-1:0] dist_reg;
    logic [AW-1:0] dist_next;
    logic [RW-1:0] cnt_reg;
    logic [RW-1:0] cnt_next;
    logic          eos_reg;
    logic          eos_next;
    logic [2:0]    code_reg;
    logic [2:0]    code_next;
    logic          post_drop_reg;
    logic          post_drop_next;
    logic          rd_vld_reg;
    logic          rd_vld_next;
    logic [7:0]    rdata_reg;
    logic          fwd_hit_reg;
    logic [7:0]    fwd_data_reg;
    logic          zero_reg;

    logic          mem_we;
    logic [7:0]    mem_wdata;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;
    logic          rd_zero;
    logic          wrapped;
    logic [CW-1:0] produced_inc;
    logic [7:0]    copy_byte;
    logic [AW:0]   iss_pos;
    logic          iss_wrap;
    logic [AW-1:0] src;
    logic          src_ok;
    logic          ovf;
    logic          last_w;

    assign wrapped      = |produced_reg[CW-1:AW];
    assign produced_inc = (produced_reg == lzfbd_pkg::COUNT_MAX) ? produced_reg
                                                                 : produced_reg + 1'b1;
    assign copy_byte    = fwd_hit_reg ? fwd_data_reg : (zero_reg ? 8'd0 : rdata_reg);
    assign iss_pos      = {1'b0, ptr_reg} + {{AW{1'b0}}, rd_vld_reg};
    assign iss_wrap     = wrapped || iss_pos[AW];
    assign src          = iss_pos[AW-1:0] - dist_reg;
    assign src_ok       = iss_wrap || ({1'b0, dist_reg} <= iss_pos);

    always_comb
    begin
        state_next     = state_reg;
        ptr_next       = ptr_reg;
        produced_next  = produced_reg;
        drop_next      = drop_reg;
        dist_next      = dist_reg;
        cnt_next       = cnt_reg;
        eos_next       = eos_reg;
        code_next      = code_reg;
        post_drop_next = post_drop_reg;
        rd_vld_next    = rd_vld_reg;
        cq_pop         = 1'b0;
        res_push       = 1'b0;
        res            = '0;
        mem_we         = 1'b0;
        mem_wdata      = copy_byte;
        mem_re         = 1'b0;
        mem_raddr      = src;
        rd_zero        = !src_ok;
        ovf            = 1'b0;
        last_w         = 1'b0;
        case (state_reg)
            BS_IDLE:
            begin
                if (!cq_empty)
                begin
                    if (drop_reg)
                    begin
                        cq_pop = 1'b1;
                        if (cmd.eos)
                        begin
                            drop_next = 1'b0;
                        end
                    end
                    else
                    begin
                        case (cmd.op)
                            lzfbd_pkg::OP_LIT:
                            begin
                                if (!oq_full)
                                begin
                                    cq_pop        = 1'b1;
                                    mem_we        = 1'b1;
                                    mem_wdata     = cmd.data;
                                    ptr_next      = ptr_reg + 1'b1;
                                    produced_next = produced_inc;
                                    res_push      = 1'b1;
                                    res.kind      = lzfbd_pkg::KIND_DATA;
                                    res.data      = cmd.data;
                                    res.status    = lzfbd_pkg::ST_OK;
                                    res.count     = produced_inc;
                                    res.run_end   = !cmd.eos;
                                    if (cmd.eos)
                                    begin
                                        state_next     = BS_STAT;
                                        code_next      = cmd.code;
                                        post_drop_next = 1'b0;
                                    end
                                end
                            end
                            lzfbd_pkg::OP_REF:
                            begin
                                cq_pop      = 1'b1;
                                dist_next   = cmd.ref_dist;
                                cnt_next    = cmd.len;
                                eos_next    = cmd.eos;
                                code_next   = cmd.code;
                                rd_vld_next = 1'b0;
                                state_next  = BS_COPY;
                            end
                            default:
                            begin
                                cq_pop         = 1'b1;
                                code_next      = cmd.code;
                                post_drop_next = !cmd.eos;
                                state_next     = BS_STAT;
                            end
                        endcase
                    end
                end
            end
            BS_COPY:
            begin
                if (!(rd_vld_reg && oq_full))
                begin
                    if (rd_vld_reg)
                    begin
                        mem_we        = 1'b1;
                        ptr_next      = ptr_reg + 1'b1;
                        produced_next = produced_inc;
                        ovf           = (produced_inc >= limit);
                        last_w        = (cnt_reg == '0);
                        res_push      = 1'b1;
                        res.kind      = lzfbd_pkg::KIND_DATA;
                        res.data      = copy_byte;
                        res.status    = lzfbd_pkg::ST_OK;
                        res.count     = produced_inc;
                        res.run_end   = last_w && !ovf && !eos_reg;
                        if (ovf)
                        begin
                            state_next     = BS_STAT;
                            code_next      = lzfbd_pkg::ST_OVERFLOW;
                            post_drop_next = !eos_reg;
                        end
                        else if (last_w)
                        begin
                            state_next     = eos_reg ? BS_STAT : BS_IDLE;
                            post_drop_next = 1'b0;
                        end
                    end
                    if ((cnt_reg != '0) && !ovf)
                    begin
                        mem_re      = 1'b1;
                        cnt_next    = cnt_reg - 1'b1;
                        rd_vld_next = 1'b1;
                    end
                    else
                    begin
                        rd_vld_next = 1'b0;
                    end
                end
            end
            BS_STAT:
            begin
                if (!oq_full)
                begin
                    res_push      = 1'b1;
                    res.kind      = lzfbd_pkg::KIND_STAT;
                    res.data      = 8'd0;
                    res.status    = code_reg;
                    res.count     = produced_reg;
                    res.run_end   = 1'b1;
                    ptr_next      = '0;
                    produced_next = '0;
                    drop_next     = post_drop_reg;
                    state_next    = BS_IDLE;
                end
            end
            default:
            begin
                state_next = BS_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BS_IDLE;
            ptr_reg       <= '0;
            produced_reg  <= '0;
            drop_reg      <= 1'b0;
            dist_reg      <= '0;
            cnt_reg       <= '0;
            eos_reg       <= 1'b0;
            code_reg      <= lzfbd_pkg::ST_OK;
            post_drop_reg <= 1'b0;
            rd_vld_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ptr_reg       <= ptr_next;
            produced_reg  <= produced_next;
            drop_reg      <= drop_next;
            dist_reg      <= dist_next;
            cnt_reg       <= cnt_next;
            eos_reg       <= eos_next;
            code_reg      <= code_next;
            post_drop_reg <= post_drop_next;
            rd_vld_reg    <= rd_vld_next;
        end
    end

    // forward the byte written this cycle when the read hits the same entry
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            hist_mem[ptr_reg] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg    <= hist_mem[mem_raddr];
            fwd_hit_reg  <= mem_we && (ptr_reg == mem_raddr);
            fwd_data_reg <= mem_wdata;
            zero_reg     <= rd_zero;
        end
    end

endmodule

// ===== design/lzss_flag_byte_decompressor_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LZSS flag-byte decompressor
// Parser and copy engine joined by a command queue, results through a queue.
// ----------------------------------------------------------------------------
// Path: a literal result passes the command queue and the result queue; the
// first byte of a reference also passes the registered history read.
// Throughput: one literal per cycle while the result queue has room; a
// reference copies 3 to 18 bytes and blocks later commands until it ends.
// Reset: control clears at once, the output limit returns to 147456. History
// needs no clearing pass: entries not yet written in a stream read as zero.
module lzss_flag_byte_decompressor_unit
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    output logic                        full,
    input  logic [7:0]                  in_byte,
    input  logic                        in_last,
    output logic                        empty,
    input  logic                        pop,
    output logic                        kind,
    output logic [7:0]                  out_byte,
    output logic [2:0]                  status,
    output logic [lzfbd_pkg::CNT_W-1:0] out_count,
    output logic                        run_end,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [lzfbd_pkg::CNT_W-1:0] cfg_data
);

    logic [lzfbd_pkg::CNT_W-1:0] limit_reg;
    logic                        cmd_push;
    lzfbd_pkg::cmd_t             cmd_in;
    lzfbd_pkg::cmd_t             cmd_out;
    logic                        cq_full;
    logic                        cq_empty;
    logic                        cq_pop;
    logic                        res_push;
    lzfbd_pkg::res_t             res_in;
    lzfbd_pkg::res_t             res_out;
    logic                        oq_full;

    assign full      = cq_full;
    assign cfg_ready = 1'b1;
    assign kind      = res_out.kind;
    assign out_byte  = res_out.data;
    assign status    = res_out.status;
    assign out_count = res_out.count;
    assign run_end   = res_out.run_end;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= lzfbd_pkg::LIMIT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            limit_reg <= cfg_data;
        end
    end

    lzfbd_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .in_byte  (in_byte),
        .in_last  (in_last),
        .cq_full  (cq_full),
        .cmd_push (cmd_push),
        .cmd      (cmd_in)
    );

    lzfbd_cq u_cq
    (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (cmd_push),
        .wdata (cmd_in),
        .full  (cq_full),
        .rd    (cq_pop),
        .rdata (cmd_out),
        .empty (cq_empty)
    );

    lzfbd_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd_out),
        .cq_empty (cq_empty),
        .cq_pop   (cq_pop),
        .limit    (limit_reg),
        .oq_full  (oq_full),
        .res_push (res_push),
        .res      (res_in)
    );

    lzfbd_oq u_oq
    (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (res_push),
        .wdata (res_in),
        .full  (oq_full),
        .rd    (pop),
        .rdata (res_out),
        .empty (empty)
    );

    a_cq_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_push |-> !cq_full)
        else $error("command pushed into full queue");

    a_oq_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> !oq_full)
        else $error("result pushed into full queue");

    a_data_item: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && kind == lzfbd_pkg::KIND_DATA)
            |-> (out_count != '0 && status == lzfbd_pkg::ST_OK))
        else $error("data item with zero count or nonzero status");

    a_stat_item: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && kind == lzfbd_pkg::KIND_STAT) |-> (out_byte == 8'd0))
        else $error("status item with nonzero byte");

endmodule
